// ===== rtl/core/electronic_fuse_controller_assert.svh =====
// Assertion macros used by the fuse controller RTL.
`ifndef ELECTRONIC_FUSE_CONTROLLER_ASSERT_SVH
`define ELECTRONIC_FUSE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define EFC_ASSERT_NOW(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define EFC_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== rtl/core/efc_pkg.sv =====
// Shared types and constants of the electronic fuse controller.
package efc_pkg;

    localparam int EV_MAX = 5;
    localparam int SLOT_W = $clog2(EV_MAX + 1);

    localparam logic [6:0] CURRENT_LIMIT_RST = 7'd45;
    localparam logic [7:0] GRACE_TICKS_RST   = 8'd3;

    localparam int PADDR_W = 3;

    typedef enum logic {
        REG_CURRENT_LIMIT = 1'b0,
        REG_GRACE_TICKS   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_AUTO_OFF    = 3'd0,
        EV_REPORT      = 3'd1,
        EV_BTN_PRESS   = 3'd2,
        EV_FUSE_ON     = 3'd3,
        EV_FUSE_OFF    = 3'd4,
        EV_BTN_RELEASE = 3'd5,
        EV_STATUS_ON   = 3'd6,
        EV_STATUS_OFF  = 3'd7
    } t_event;

    typedef struct packed {
        logic [6:0] current_limit;
        logic [7:0] grace_ticks;
    } t_cfg;

    typedef struct packed {
        logic       sample_valid;
        logic [7:0] adc_high;
        logic       tick;
        logic       button_down;
        logic       status_active;
    } t_poll;

    typedef struct packed {
        t_event code;
        logic   fuse;
    } t_evt;

    typedef struct packed {
        logic [SLOT_W-1:0]      cnt;
        logic [6:0]             current;
        t_evt [EV_MAX-1:0]      ev;
    } t_batch;

endpackage

// ===== rtl/core/efc_regs.sv =====
// APB configuration registers: trip threshold and grace tick count.
module efc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output efc_pkg::t_cfg                o_cfg
);
    import efc_pkg::*;

    logic [6:0] r_current_limit;
    logic [7:0] r_grace_ticks;
    logic       wr_en;
    t_reg_idx   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit <= CURRENT_LIMIT_RST;
            r_grace_ticks   <= GRACE_TICKS_RST;
        end else if (wr_en) begin
            case (idx)
                REG_CURRENT_LIMIT: r_current_limit <= pwdata[6:0];
                REG_GRACE_TICKS:   r_grace_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CURRENT_LIMIT: prdata = {25'd0, r_current_limit};
            REG_GRACE_TICKS:   prdata = {24'd0, r_grace_ticks};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = '{current_limit: r_current_limit, grace_ticks: r_grace_ticks};

endmodule

// ===== rtl/core/efc_eval.sv =====
// Input register, fuse state and per-poll event batch evaluation.
module efc_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  efc_pkg::t_poll  i_poll,
    input  efc_pkg::t_cfg   i_cfg,
    input  logic            i_batch_ready,
    output logic            o_batch_load,
    output efc_pkg::t_batch o_batch
);
    import efc_pkg::*;

    logic        r_in_valid;
    t_poll       r_in;
    logic        r_fuse_on;
    logic [7:0]  r_grace_count;
    logic [6:0]  r_current;
    logic        r_button_held;
    logic        r_status_seen;

    logic        n_fuse_on;
    logic [7:0]  n_grace_count;
    logic [6:0]  n_current;
    logic        n_button_held;
    logic        n_status_seen;
    t_batch      n_batch;
    logic [SLOT_W-1:0] k;

    logic fire;
    logic accept;

    always_comb begin
        n_fuse_on     = r_fuse_on;
        n_grace_count = r_grace_count;
        n_button_held = r_button_held;
        n_status_seen = r_status_seen;
        n_current     = r_in.sample_valid ? r_in.adc_high[7:1] : r_current;
        n_batch       = '0;
        k             = '0;

        if (r_in.tick && r_fuse_on) begin
            if (r_grace_count < i_cfg.grace_ticks) begin
                n_grace_count = r_grace_count + 8'd1;
            end else if (n_current > i_cfg.current_limit) begin
                n_fuse_on = 1'b0;
                n_batch.ev[k] = '{code: EV_AUTO_OFF, fuse: n_fuse_on};
                k = k + 1'b1;
            end
            n_batch.ev[k] = '{code: EV_REPORT, fuse: n_fuse_on};
            k = k + 1'b1;
        end

        if (r_in.button_down) begin
            if (!r_button_held) begin
                n_button_held = 1'b1;
                n_batch.ev[k] = '{code: EV_BTN_PRESS, fuse: n_fuse_on};
                k = k + 1'b1;
                if (n_fuse_on) begin
                    n_fuse_on = 1'b0;
                    n_batch.ev[k] = '{code: EV_FUSE_OFF, fuse: 1'b0};
                end else begin
                    n_fuse_on     = 1'b1;
                    n_grace_count = '0;
                    n_batch.ev[k] = '{code: EV_FUSE_ON, fuse: 1'b1};
                end
                k = k + 1'b1;
            end
        end else if (r_button_held) begin
            n_button_held = 1'b0;
            n_batch.ev[k] = '{code: EV_BTN_RELEASE, fuse: n_fuse_on};
            k = k + 1'b1;
        end

        if (r_in.status_active) begin
            if (!r_status_seen) begin
                n_status_seen = 1'b1;
                n_batch.ev[k] = '{code: EV_STATUS_ON, fuse: n_fuse_on};
                k = k + 1'b1;
            end
        end else if (r_status_seen) begin
            n_status_seen = 1'b0;
            n_batch.ev[k] = '{code: EV_STATUS_OFF, fuse: n_fuse_on};
            k = k + 1'b1;
        end

        n_batch.cnt     = k;
        n_batch.current = n_current;
    end

    assign fire         = r_in_valid && ((n_batch.cnt == '0) || i_batch_ready);
    assign o_in_stall   = r_in_valid && !fire;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_batch_load = fire && (n_batch.cnt != '0);
    assign o_batch      = n_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_fuse_on     <= 1'b0;
            r_grace_count <= '0;
            r_current     <= '0;
            r_button_held <= 1'b0;
            r_status_seen <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
            if (fire) begin
                r_fuse_on     <= n_fuse_on;
                r_grace_count <= n_grace_count;
                r_current     <= n_current;
                r_button_held <= n_button_held;
                r_status_seen <= n_status_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_poll;
        end
    end

endmodule

// ===== rtl/core/efc_emit.sv =====
// Result register: holds one event batch and sends its events one per cycle while the output is not stalled.
`include "electronic_fuse_controller_assert.svh"

module efc_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_batch_load,
    input  efc_pkg::t_batch i_batch,
    output logic            o_batch_ready,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_event_res,
    output logic [6:0]      o_current_tenths,
    output logic            o_fuse_drive,
    output logic            o_last
);
    import efc_pkg::*;

    logic              r_busy;
    logic [SLOT_W-1:0] r_idx;
    t_batch            r_batch;
    logic              pop;
    logic              is_last;
    t_evt              cur_ev;

    assign is_last = (r_idx == r_batch.cnt - 1'b1);
    assign pop     = r_busy && !i_out_stall;
    assign o_batch_ready = !r_busy || (pop && is_last);

    assign cur_ev           = r_batch.ev[r_idx];
    assign o_out_valid      = r_busy;
    assign o_event_res      = cur_ev.code;
    assign o_fuse_drive     = cur_ev.fuse;
    assign o_current_tenths = r_batch.current;
    assign o_last           = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_batch_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (pop) begin
            if (is_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_batch_load) begin
            r_batch <= i_batch;
        end
    end

    `EFC_ASSERT_NOW(a_idx_in_batch, r_busy, (r_batch.cnt != '0) && (r_idx < r_batch.cnt), "event index outside batch")
    `EFC_ASSERT_NEXT(a_mid_batch_stays, pop && !is_last, r_busy && (r_idx == $past(r_idx) + 1'b1), "batch dropped before last event")
    `EFC_ASSERT_NEXT(a_stall_holds, r_busy && i_out_stall, r_busy && $stable(r_idx), "stalled event moved")
    `EFC_ASSERT_NOW(a_no_load_busy, i_batch_load, o_batch_ready, "batch loaded over pending events")

endmodule

// ===== rtl/core/electronic_fuse_controller.sv =====
// Top level of the electronic fuse controller.
// A poll item passes the input register, then its events the result register, before the first event is offered.
// Throughput: one poll per cycle while not stalled; a poll with events (up to 5) holds the input until the
// result register can take its batch. Event serialization there is what sets the multi-event rate.
// Reset (synchronous, active low): fuse off, counters and levels cleared, registers 45 and 3.
module electronic_fuse_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_sample_valid,
    input  logic [7:0]                   i_adc_high,
    input  logic                         i_tick,
    input  logic                         i_button_down,
    input  logic                         i_status_active,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_event_res,
    output logic [6:0]                   o_current_tenths,
    output logic                         o_fuse_drive,
    output logic                         o_last
);
    import efc_pkg::*;

    t_cfg   cfg;
    t_poll  poll;
    t_batch batch;
    logic   batch_load;
    logic   batch_ready;

    assign poll = '{sample_valid:  i_sample_valid,
                    adc_high:      i_adc_high,
                    tick:          i_tick,
                    button_down:   i_button_down,
                    status_active: i_status_active};

    efc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    efc_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_poll        (poll),
        .i_cfg         (cfg),
        .i_batch_ready (batch_ready),
        .o_batch_load  (batch_load),
        .o_batch       (batch)
    );

    efc_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_batch_load     (batch_load),
        .i_batch          (batch),
        .o_batch_ready    (batch_ready),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_current_tenths (o_current_tenths),
        .o_fuse_drive     (o_fuse_drive),
        .o_last           (o_last)
    );

endmodule
